[rtl/smtcc_pkg.sv]
// Shared types and constants for the smart meter telegram CRC checker.
// No dependencies; every other file of the block refers to this package.
`timescale 1ns / 1ps
`default_nettype none

package smtcc_pkg;

    localparam int LEN_W    = 13;
    localparam int CRC_W    = 16;
    localparam int IDLE_W   = 16;
    localparam int STATUS_W = 3;
    localparam int CFG_W    = 16;

    // Effective length cap; the programmed max_length is clipped to it.
    localparam logic [LEN_W-1:0]  LENGTH_LIMIT     = 13'd4096;
    localparam logic [LEN_W-1:0]  MAX_LENGTH_RESET = 13'd4096;
    localparam logic [IDLE_W-1:0] IDLE_LIMIT_RESET = 16'd300;

    // CRC-16/ARC, reflected polynomial, zero init, no final xor
    localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;
    localparam logic [CRC_W-1:0] CRC_INIT = 16'h0000;

    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_BANG  = 8'h21;

    // Configuration register indexes
    localparam logic CFG_MAX_LENGTH = 1'b0;
    localparam logic CFG_IDLE_LIMIT = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MISMATCH = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NODIGITS = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TOOLONG  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT  = 3'd4;

    // Classified input word, as queued between front and back
    typedef struct packed {
        logic       is_idle;
        logic       is_slash;
        logic       is_bang;
        logic       hex_ok;
        logic [3:0] hex_nib;
        logic [7:0] data;
    } word_t;

    typedef struct packed {
        logic [LEN_W-1:0]  max_length;
        logic [IDLE_W-1:0] idle_limit;
    } cfg_t;

endpackage

`default_nettype wire

[rtl/smtcc_ifs.sv]
// Valid/ready channel interfaces for the telegram CRC checker.
// Depends on smtcc_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface smtcc_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] data_byte;

    modport source (output valid, output operation, output data_byte, input ready);
    modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

interface smtcc_out_if;
    logic                          valid;
    logic                          ready;
    logic [smtcc_pkg::STATUS_W-1:0] status;
    logic [smtcc_pkg::LEN_W-1:0]    frame_length;
    logic [smtcc_pkg::CRC_W-1:0]    rx_crc;
    logic [smtcc_pkg::CRC_W-1:0]    computed_crc;

    modport source (output valid, output status, output frame_length,
                    output rx_crc, output computed_crc, input ready);
    modport sink   (input valid, input status, input frame_length,
                    input rx_crc, input computed_crc, output ready);
endinterface

`default_nettype wire

[rtl/smtcc_front.sv]
// Front end: takes input words and classifies each byte (start, end mark, hex).
// Depends on smtcc_pkg and smtcc_ifs.
`timescale 1ns / 1ps
`default_nettype none

module smtcc_front (
    smtcc_in_if.sink              in_word,
    input  wire logic             queue_full,
    output logic                  push,
    output smtcc_pkg::word_t      push_word
);

    logic [7:0] b;

    assign b             = in_word.data_byte;
    assign in_word.ready = !queue_full;
    assign push          = in_word.valid && !queue_full;

    always_comb
    begin
        push_word          = '0;
        push_word.is_idle  = in_word.operation;
        push_word.data     = b;
        push_word.is_slash = (b == smtcc_pkg::CHAR_SLASH);
        push_word.is_bang  = (b == smtcc_pkg::CHAR_BANG);
        if (b >= 8'h30 && b <= 8'h39)
        begin
            push_word.hex_ok  = 1'b1;
            push_word.hex_nib = 4'(b - 8'h30);
        end
        else if (b >= 8'h41 && b <= 8'h46)
        begin
            push_word.hex_ok  = 1'b1;
            push_word.hex_nib = 4'(b - 8'h37);
        end
        else if (b >= 8'h61 && b <= 8'h66)
        begin
            push_word.hex_ok  = 1'b1;
            push_word.hex_nib = 4'(b - 8'h57);
        end
    end

endmodule

`default_nettype wire

[rtl/smtcc_queue.sv]
// Short word queue between front and back, show-ahead read.
// Depends on smtcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smtcc_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire smtcc_pkg::word_t  push_word,
    output logic                   full,
    input  wire logic              pop,
    output logic                   head_valid,
    output smtcc_pkg::word_t       head_word
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    smtcc_pkg::word_t  mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_word  = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_word;
    end

endmodule

`default_nettype wire

[rtl/smtcc_back.sv]
// Back end: frame state machine, CRC-16/ARC update and result register.
// Depends on smtcc_pkg and smtcc_ifs.
`timescale 1ns / 1ps
`default_nettype none

module smtcc_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire smtcc_pkg::cfg_t  cfg,
    input  wire logic             word_valid,
    input  wire smtcc_pkg::word_t word,
    output logic                  word_pop,
    smtcc_out_if.source           out_word
);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_BODY,
        PH_DIGITS
    } phase_t;

    function automatic logic [smtcc_pkg::CRC_W-1:0] crc_byte(
        input logic [smtcc_pkg::CRC_W-1:0] crc_in,
        input logic [7:0]                  b
    );
        logic [smtcc_pkg::CRC_W-1:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
            c = c[0] ? ((c >> 1) ^ smtcc_pkg::CRC_POLY) : (c >> 1);
        return c;
    endfunction

    phase_t                          phase_reg, phase_next;
    logic [smtcc_pkg::LEN_W-1:0]     count_reg, count_next;
    logic [smtcc_pkg::CRC_W-1:0]     crc_reg, crc_next;
    logic [2:0]                      dcnt_reg, dcnt_next;
    logic [smtcc_pkg::CRC_W-1:0]     dval_reg, dval_next;
    logic [smtcc_pkg::IDLE_W-1:0]    idle_reg, idle_next;

    logic                            ovalid_reg, ovalid_next;
    logic [smtcc_pkg::STATUS_W-1:0]  ostatus_reg, ostatus_next;
    logic [smtcc_pkg::LEN_W-1:0]     olen_reg, olen_next;
    logic [smtcc_pkg::CRC_W-1:0]     orx_reg, orx_next;
    logic [smtcc_pkg::CRC_W-1:0]     ocrc_reg, ocrc_next;

    logic                            slot_free;
    logic                            fin;
    logic [smtcc_pkg::STATUS_W-1:0]  fin_status;
    logic [smtcc_pkg::CRC_W-1:0]     fin_rx;
    logic [smtcc_pkg::LEN_W-1:0]     eff_limit;
    logic [smtcc_pkg::IDLE_W-1:0]    idle_lim;
    logic [smtcc_pkg::IDLE_W-1:0]    idle_inc;
    logic [smtcc_pkg::CRC_W-1:0]     dval_shift;
    logic [2:0]                      dcnt_inc;

    assign slot_free  = !ovalid_reg || out_word.ready;
    assign eff_limit  = (cfg.max_length < smtcc_pkg::LENGTH_LIMIT) ? cfg.max_length
                                                                   : smtcc_pkg::LENGTH_LIMIT;
    assign idle_lim   = (cfg.idle_limit == '0) ? smtcc_pkg::IDLE_W'(1) : cfg.idle_limit;
    assign idle_inc   = idle_reg + smtcc_pkg::IDLE_W'(1);
    assign dval_shift = {dval_reg[smtcc_pkg::CRC_W-5:0], word.hex_nib};
    assign dcnt_inc   = dcnt_reg + 3'd1;

    // Frame decision for the head word
    always_comb
    begin
        fin        = 1'b0;
        fin_status = smtcc_pkg::ST_OK;
        fin_rx     = '0;
        phase_next = phase_reg;
        count_next = count_reg;
        crc_next   = crc_reg;
        dcnt_next  = dcnt_reg;
        dval_next  = dval_reg;
        idle_next  = idle_reg;
        case (phase_reg)
            PH_HUNT:
            begin
                if (!word.is_idle && word.is_slash)
                begin
                    phase_next = PH_BODY;
                    count_next = smtcc_pkg::LEN_W'(1);
                    crc_next   = crc_byte(smtcc_pkg::CRC_INIT, smtcc_pkg::CHAR_SLASH);
                    dcnt_next  = '0;
                    dval_next  = '0;
                    idle_next  = '0;
                end
            end
            PH_BODY, PH_DIGITS:
            begin
                if (word.is_idle)
                begin
                    idle_next = idle_inc;
                    if (idle_inc >= idle_lim)
                    begin
                        fin        = 1'b1;
                        fin_status = (phase_reg == PH_BODY) ? smtcc_pkg::ST_TIMEOUT
                                                            : smtcc_pkg::ST_NODIGITS;
                    end
                end
                else
                begin
                    idle_next = '0;
                    if (phase_reg == PH_BODY)
                    begin
                        if (count_reg >= eff_limit)
                        begin
                            fin        = 1'b1;
                            fin_status = smtcc_pkg::ST_TOOLONG;
                        end
                        else
                        begin
                            crc_next   = crc_byte(crc_reg, word.data);
                            count_next = count_reg + smtcc_pkg::LEN_W'(1);
                            if (word.is_bang)
                            begin
                                phase_next = PH_DIGITS;
                                dcnt_next  = '0;
                                dval_next  = '0;
                            end
                        end
                    end
                    else if (word.hex_ok)
                    begin
                        dval_next = dval_shift;
                        dcnt_next = dcnt_inc;
                        if (dcnt_inc >= 3'd4)
                        begin
                            fin        = 1'b1;
                            fin_rx     = dval_shift;
                            fin_status = (dval_shift == crc_reg) ? smtcc_pkg::ST_OK
                                                                 : smtcc_pkg::ST_MISMATCH;
                        end
                    end
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
        if (fin)
        begin
            phase_next = PH_HUNT;
            count_next = '0;
            crc_next   = '0;
            dcnt_next  = '0;
            dval_next  = '0;
            idle_next  = '0;
        end
    end

    // A word that ends a frame waits until the result register can take it
    assign word_pop = word_valid && (!fin || slot_free);

    always_comb
    begin
        ovalid_next  = ovalid_reg;
        ostatus_next = ostatus_reg;
        olen_next    = olen_reg;
        orx_next     = orx_reg;
        ocrc_next    = ocrc_reg;
        if (slot_free)
        begin
            ovalid_next = word_pop && fin;
            if (word_pop && fin)
            begin
                ostatus_next = fin_status;
                olen_next    = count_reg;
                orx_next     = fin_rx;
                ocrc_next    = crc_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT;
            count_reg   <= '0;
            crc_reg     <= '0;
            dcnt_reg    <= '0;
            dval_reg    <= '0;
            idle_reg    <= '0;
            ovalid_reg  <= 1'b0;
            ostatus_reg <= smtcc_pkg::ST_OK;
            olen_reg    <= '0;
            orx_reg     <= '0;
            ocrc_reg    <= '0;
        end
        else
        begin
            if (word_pop)
            begin
                phase_reg <= phase_next;
                count_reg <= count_next;
                crc_reg   <= crc_next;
                dcnt_reg  <= dcnt_next;
                dval_reg  <= dval_next;
                idle_reg  <= idle_next;
            end
            ovalid_reg  <= ovalid_next;
            ostatus_reg <= ostatus_next;
            olen_reg    <= olen_next;
            orx_reg     <= orx_next;
            ocrc_reg    <= ocrc_next;
        end
    end

    assign out_word.valid        = ovalid_reg;
    assign out_word.status       = ostatus_reg;
    assign out_word.frame_length = olen_reg;
    assign out_word.rx_crc       = orx_reg;
    assign out_word.computed_crc = ocrc_reg;

endmodule

`default_nettype wire

[rtl/smart_meter_telegram_crc_checker_unit.sv]
// Top level of the smart meter telegram CRC checker: config registers,
// front classifier, word queue and back frame engine. Uses smtcc_pkg, smtcc_ifs.
`timescale 1ns / 1ps
`default_nettype none

// Channel    Dir  Handshake     Word
// in_word    in   valid/ready   operation (byte or idle tick), data_byte
// out_word   out  valid/ready   status, frame_length, rx_crc, computed_crc
// cfg        in   cfg_we only   cfg_index selects max_length / idle_limit
//
// One word is accepted per clock as long as the queue has room; the back end
// retires one word per clock when not stalled, the 8-bit CRC step being
// fully unrolled there. A result goes through the queue and the result register
// to out_word. Only a frame-ending word stalls, and only while the result
// register is held by a stalled out_word; later words wait in the queue.
// Reset (rst_n low, async) empties the queue, returns to hunting for '/' and
// restores max_length = 4096 and idle_limit = 300.

module smart_meter_telegram_crc_checker_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    smtcc_in_if.sink                          in_word,
    smtcc_out_if.source                       out_word,
    input  wire logic                         cfg_we,
    input  wire logic                         cfg_index,
    input  wire logic [smtcc_pkg::CFG_W-1:0]  cfg_data
);

    smtcc_pkg::cfg_t   cfg_reg, cfg_next;
    logic              q_full;
    logic              q_push;
    smtcc_pkg::word_t  q_push_word;
    logic              q_head_valid;
    smtcc_pkg::word_t  q_head_word;
    logic              q_pop;

    // Configuration writes; user must let these arrive while idle; not enforced
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                smtcc_pkg::CFG_MAX_LENGTH:
                    cfg_next.max_length = cfg_data[smtcc_pkg::LEN_W-1:0];
                smtcc_pkg::CFG_IDLE_LIMIT:
                    cfg_next.idle_limit = cfg_data[smtcc_pkg::IDLE_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_length <= smtcc_pkg::MAX_LENGTH_RESET;
            cfg_reg.idle_limit <= smtcc_pkg::IDLE_LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: accept and classify
    smtcc_front u_front (
        .in_word    (in_word),
        .queue_full (q_full),
        .push       (q_push),
        .push_word  (q_push_word)
    );

    // Queue decouples acceptance from the frame engine
    smtcc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_word  (q_push_word),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_word  (q_head_word)
    );

    // Back: framing, CRC, digit capture, result register
    smtcc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .word_valid (q_head_valid),
        .word       (q_head_word),
        .word_pop   (q_pop),
        .out_word   (out_word)
    );

    // A passing check must carry matching CRCs
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_word.valid && out_word.status == smtcc_pkg::ST_OK)
            |-> (out_word.rx_crc == out_word.computed_crc))
        else $error("ok status with differing crc values");

    // Error endings carry no received digits
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_word.valid && (out_word.status == smtcc_pkg::ST_TOOLONG ||
                            out_word.status == smtcc_pkg::ST_TIMEOUT ||
                            out_word.status == smtcc_pkg::ST_NODIGITS))
            |-> (out_word.rx_crc == '0))
        else $error("error result carries a received crc");

    // Frame length never passes the hard cap
    assert property (@(posedge clk) disable iff (!rst_n)
        out_word.valid |-> (out_word.frame_length <= smtcc_pkg::LENGTH_LIMIT))
        else $error("frame length beyond cap");

    // A stalled result stays valid until out_word takes it
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_word.valid && !out_word.ready) |=> out_word.valid)
        else $error("stalled result dropped");

endmodule

`default_nettype wire
